// ===== rtl/rcfr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and register indexes of the rc channel frame receiver
// no dependencies

package rcfr_pkg;

    localparam int CHANNELS_DEFAULT = 14;
    localparam int CH_W             = 4;
    localparam int VAL_W            = 16;
    localparam int CFG_W            = 64;
    localparam int CFG_IDX_W        = 3;

    localparam logic [VAL_W-1:0] LOW_LIMIT  = 16'd950;
    localparam logic [VAL_W-1:0] HIGH_LIMIT = 16'd2050;

    localparam logic [63:0] DEF_QUAD_RESET = 64'h05DC_05DC_05DC_05DC;
    localparam logic [31:0] DEF_PAIR_RESET = 32'h05DC_05DC;
    localparam logic [15:0] DEAD_RESET     = 16'd1000;
    localparam logic [15:0] HEADER_RESET   = 16'h2040;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEF_CH0_3   = 3'd0,
        REG_DEF_CH4_7   = 3'd1,
        REG_DEF_CH8_11  = 3'd2,
        REG_DEF_CH12_13 = 3'd3,
        REG_DEAD_TIME   = 3'd4,
        REG_HEADER      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel_index;
        logic [VAL_W-1:0] channel_value;
        logic             replaced;
        logic             failsafe;
        logic             last;
        logic             link_alive;
    } out_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] data;
        logic [VAL_W-1:0] dflt;
        logic             failsafe;
    } chk_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             replaced;
    } chk_resp_t;

endpackage

// ===== rtl/rcfr_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module rcfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 14
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rcfr_check.sv =====
`timescale 1ns / 1ps
// shared range check unit: picks the received value or the channel default
// depends on rcfr_pkg

module rcfr_check (
    input  rcfr_pkg::chk_req_t  req,
    output rcfr_pkg::chk_resp_t resp
);

    import rcfr_pkg::*;

    logic out_of_range;

    assign out_of_range = (req.data <= LOW_LIMIT) || (req.data >= HIGH_LIMIT);

    always_comb
    begin
        if (req.failsafe)
        begin
            resp.value    = req.dflt;
            resp.replaced = 1'b0;
        end
        else if (out_of_range)
        begin
            resp.value    = req.dflt;
            resp.replaced = 1'b1;
        end
        else
        begin
            resp.value    = req.data;
            resp.replaced = 1'b0;
        end
    end

endmodule

// ===== rtl/rc_channel_frame_receiver.sv =====
`timescale 1ns / 1ps
// rc channel frame receiver top level: framer, link timer and channel walk sequencer
// depends on rcfr_pkg, rcfr_ram, rcfr_check
// input: a byte or tick item that ends nothing is taken and the input stays ready
// frame end or failsafe: the walk takes each channel through ram read, range check and
// output hand-off, held by any output stall, with input stalled throughout
// reset: config registers to their defaults, framer hunting, link down, no clearing pass

module rc_channel_frame_receiver #(
    parameter int CHANNELS = rcfr_pkg::CHANNELS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  rcfr_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output rcfr_pkg::out_item_t                   out_item,
    input  logic                                  cfg_write,
    input  logic [rcfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcfr_pkg::CFG_W-1:0]            cfg_data
);

    import rcfr_pkg::*;

    localparam int STORE_BYTES   = 2 * CHANNELS;
    localparam int PAYLOAD_BYTES = 2 * CHANNELS + 2;
    localparam int PCW           = $clog2(PAYLOAD_BYTES + 1);
    localparam int AW            = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HDR1,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_WAIT
    } state_t;

    // config registers
    logic [63:0]      def0_reg, def1_reg, def2_reg;
    logic [31:0]      def3_reg;
    logic [15:0]      dead_reg;
    logic [15:0]      header_reg;

    // framer and link state
    phase_t           phase_reg, phase_next;
    logic [PCW-1:0]   count_reg, count_next;
    logic [7:0]       lo_byte_reg, lo_byte_next;
    logic             link_up_reg, link_up_next;
    logic [15:0]      idle_reg, idle_next;

    // sequencer
    state_t           state_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             fs_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             accept;
    logic             start_walk;
    logic             start_fs;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [15:0]      ram_rdata;
    logic [15:0]      dflt;
    logic             ch_last;
    logic [7:0]       hdr_hi;
    logic [7:0]       hdr_lo;
    chk_req_t         chk_req;
    chk_resp_t        chk_resp;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign hdr_hi    = header_reg[15:8];
    assign hdr_lo    = header_reg[7:0];
    assign ram_waddr = AW'(count_reg >> 1);
    assign ch_last   = (ch_reg == CH_W'(CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def0_reg   <= DEF_QUAD_RESET;
            def1_reg   <= DEF_QUAD_RESET;
            def2_reg   <= DEF_QUAD_RESET;
            def3_reg   <= DEF_PAIR_RESET;
            dead_reg   <= DEAD_RESET;
            header_reg <= HEADER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEF_CH0_3:   def0_reg   <= cfg_data;
                REG_DEF_CH4_7:   def1_reg   <= cfg_data;
                REG_DEF_CH8_11:  def2_reg   <= cfg_data;
                REG_DEF_CH12_13: def3_reg   <= cfg_data[31:0];
                REG_DEAD_TIME:   dead_reg   <= cfg_data[15:0];
                REG_HEADER:      header_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        lo_byte_next = lo_byte_reg;
        link_up_next = link_up_reg;
        idle_next    = idle_reg;
        ram_we       = 1'b0;
        start_walk   = 1'b0;
        start_fs     = 1'b0;
        if (accept)
        begin
            if (in_item.mode)
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 16'd1;
                end
                if (link_up_reg && (idle_next > dead_reg))
                begin
                    link_up_next = 1'b0;
                    start_fs     = 1'b1;
                end
            end
            else
            begin
                link_up_next = 1'b1;
                idle_next    = '0;
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_item.rx_byte == hdr_hi)
                        begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_HDR1:
                    begin
                        if (in_item.rx_byte == hdr_lo)
                        begin
                            phase_next = PH_DATA;
                            count_next = '0;
                        end
                        else if (in_item.rx_byte != hdr_hi)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_DATA:
                    begin
                        if (count_reg < PCW'(STORE_BYTES))
                        begin
                            if (!count_reg[0])
                            begin
                                lo_byte_next = in_item.rx_byte;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        count_next = count_reg + PCW'(1);
                        if (count_next >= PCW'(PAYLOAD_BYTES))
                        begin
                            phase_next = PH_HUNT;
                            count_next = '0;
                            start_walk = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            lo_byte_reg <= '0;
            link_up_reg <= 1'b0;
            idle_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            lo_byte_reg <= lo_byte_next;
            link_up_reg <= link_up_next;
            idle_reg    <= idle_next;
        end
    end

    rcfr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_item.rx_byte, lo_byte_reg}),
        .raddr (ch_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // channel default, zero for channels 14 and 15
    always_comb
    begin
        case (ch_reg[3:2])
            2'd0:    dflt = def0_reg[{ch_reg[1:0], 4'b0000} +: 16];
            2'd1:    dflt = def1_reg[{ch_reg[1:0], 4'b0000} +: 16];
            2'd2:    dflt = def2_reg[{ch_reg[1:0], 4'b0000} +: 16];
            default: dflt = ch_reg[1] ? 16'd0 : def3_reg[{ch_reg[0], 4'b0000} +: 16];
        endcase
    end

    assign chk_req.data     = ram_rdata;
    assign chk_req.dflt     = dflt;
    assign chk_req.failsafe = fs_reg;

    rcfr_check u_check (
        .req  (chk_req),
        .resp (chk_resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            fs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start_walk || start_fs)
                    begin
                        ch_reg    <= '0;
                        fs_reg    <= start_fs;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    out_valid_reg              <= 1'b1;
                    out_item_reg.channel_index <= ch_reg;
                    out_item_reg.channel_value <= chk_resp.value;
                    out_item_reg.replaced      <= chk_resp.replaced;
                    out_item_reg.failsafe      <= fs_reg;
                    out_item_reg.last          <= ch_last;
                    out_item_reg.link_alive    <= link_up_reg;
                    state_reg                  <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (ch_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_fs_link_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.failsafe |-> !out_item.link_alive)
        else $error("failsafe item with link alive");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last |-> out_item.channel_index == CH_W'(CHANNELS - 1))
        else $error("last flag on wrong channel");

    a_byte_alive: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !in_item.mode |=> link_up_reg && idle_reg == 16'd0)
        else $error("byte did not mark link alive");

    a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input ready while an item is pending");

    a_gap_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("output valid right after hand-off");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of rc_channel_frame_receiver: clocked driver and monitor, queued items
// depends on rcfr_pkg and the rc_channel_frame_receiver rtl

module tb_top;
    import rcfr_pkg::*;

    localparam int NCH          = CHANNELS_DEFAULT;
    localparam int STORE_BYTES  = 2 * NCH;
    localparam int FRAME_BYTES  = 2 * NCH + 2;
    localparam int SETTLE       = 3 * NCH + 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam logic [15:0] VALUE_MAX = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_HEADER + 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    typedef enum logic [1:0] {
        HUNTING,
        HEADER_HI_SEEN,
        IN_PAYLOAD
    } framer_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    rc_channel_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state and configuration
    logic [63:0]   model_defaults [4];
    logic [15:0]   model_dead;
    logic [15:0]   model_header;
    framer_state_t model_phase;
    int            model_count;
    logic [7:0]    model_store [STORE_BYTES];
    logic          model_link;
    int            model_idle;

    in_item_t  rx_events [$];
    out_item_t expected_channels [$];
    logic [15:0] frame_values [NCH];

    int errors = 0;
    int stim_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int cycle_count = 0;
    bit no_gaps = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    function automatic logic [15:0] channel_default(input int ch);
        logic [63:0] r;
        r = model_defaults[ch / 4];
        return r[16 * (ch % 4) +: 16];
    endfunction

    task automatic queue_channel(input int ch, input logic [15:0] v, input logic rep,
                                 input logic fs);
        out_item_t r;
        r.channel_index = ch[CH_W-1:0];
        r.channel_value = v;
        r.replaced      = rep;
        r.failsafe      = fs;
        r.last          = (ch == NCH - 1);
        r.link_alive    = model_link;
        expected_channels.push_back(r);
    endtask

    task automatic advance_receiver(input in_item_t it);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] v;
        int          ch;
        hi = model_header[15:8];
        lo = model_header[7:0];
        if (it.mode)
        begin
            if (model_idle < VALUE_MAX)
                model_idle++;
            if (model_link && model_idle > model_dead)
            begin
                model_link = 1'b0;
                for (ch = 0; ch < NCH; ch++)
                    queue_channel(ch, channel_default(ch), 1'b0, 1'b1);
            end
        end
        else
        begin
            model_link = 1'b1;
            model_idle = 0;
            case (model_phase)
                HUNTING:
                    if (it.rx_byte == hi)
                        model_phase = HEADER_HI_SEEN;
                HEADER_HI_SEEN:
                    if (it.rx_byte == lo)
                    begin
                        model_phase = IN_PAYLOAD;
                        model_count = 0;
                    end
                    else if (it.rx_byte != hi)
                        model_phase = HUNTING;
                default:
                begin
                    if (model_count < STORE_BYTES)
                        model_store[model_count] = it.rx_byte;
                    model_count++;
                    if (model_count >= FRAME_BYTES)
                    begin
                        model_phase = HUNTING;
                        model_count = 0;
                        for (ch = 0; ch < NCH; ch++)
                        begin
                            v = {model_store[2 * ch + 1], model_store[2 * ch]};
                            if (v <= LOW_LIMIT || v >= HIGH_LIMIT)
                                queue_channel(ch, channel_default(ch), 1'b1, 1'b0);
                            else
                                queue_channel(ch, v, 1'b0, 1'b0);
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endtask

    task automatic check_channel(input out_item_t got);
        out_item_t want;
        if (expected_channels.size() == 0)
        begin
            errors++;
            $display("%0t: result expected none actual %h", $time, got);
            return;
        end
        want = expected_channels.pop_front();
        if (got.channel_index !== want.channel_index)
            report_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
        if (got.channel_value !== want.channel_value)
            report_field("channel_value", 32'(want.channel_value), 32'(got.channel_value));
        if (got.replaced !== want.replaced)
            report_field("replaced", 32'(want.replaced), 32'(got.replaced));
        if (got.failsafe !== want.failsafe)
            report_field("failsafe", 32'(want.failsafe), 32'(got.failsafe));
        if (got.last !== want.last)
            report_field("last", 32'(want.last), 32'(got.last));
        if (got.link_alive !== want.link_alive)
            report_field("link_alive", 32'(want.link_alive), 32'(got.link_alive));
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_receiver(in_item);
                void'(rx_events.pop_front());
            end
            if (in_valid && in_stall)
                ;
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (rx_events.size() != 0 && !no_gaps && $urandom_range(0, 11) == 0)
            begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 7);
            end
            else if (rx_events.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item  <= rx_events[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_channel(out_item);
            if (hold_left != 0)
                out_stall <= 1'b1;
            else if (recv_gap != 0)
            begin
                out_stall <= 1'b1;
                recv_gap--;
            end
            else if (!no_gaps && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                recv_gap = $urandom_range(0, 7);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // long receiver hold-off, once
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rc_channel_frame_receiver] ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        in_item_t it;
        it.mode    = 1'b0;
        it.rx_byte = b;
        rx_events.push_back(it);
        stim_count++;
    endtask

    task automatic push_ticks(input int n);
        in_item_t it;
        repeat (n)
        begin
            it.mode    = 1'b1;
            it.rx_byte = 8'($urandom);
            rx_events.push_back(it);
            stim_count++;
        end
    endtask

    task automatic push_frame(input int cut_at, input int tick_at, input int tick_n);
        logic [7:0] b;
        int i;
        push_byte(model_header[15:8]);
        push_byte(model_header[7:0]);
        for (i = 0; i < FRAME_BYTES; i++)
        begin
            if (i == cut_at)
                break;
            if (i == tick_at)
                push_ticks(tick_n);
            if (i < STORE_BYTES)
                b = frame_values[i / 2][8 * (i % 2) +: 8];
            else
                b = 8'($urandom);
            push_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_channel_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return LOW_LIMIT;
                    1:       return LOW_LIMIT + 16'd1;
                    2:       return HIGH_LIMIT - 16'd1;
                    default: return HIGH_LIMIT;
                endcase
            1:       return 16'($urandom_range(0, LOW_LIMIT));
            2:       return 16'($urandom_range(HIGH_LIMIT, VALUE_MAX));
            3:       return {model_header[7:0], model_header[15:8]};
            default: return 16'($urandom_range(LOW_LIMIT + 1, HIGH_LIMIT - 1));
        endcase
    endfunction

    task automatic fill_random_values();
        int ch;
        for (ch = 0; ch < NCH; ch++)
            frame_values[ch] = pick_channel_value();
    endtask

    task automatic push_random(input int n);
        int start;
        int sel;
        int burst;
        start = stim_count;
        while (stim_count - start < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                fill_random_values();
                push_frame(-1, ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_BYTES - 1)
                                                          : -1, $urandom_range(1, 3));
            end
            else if (sel < 78)
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
            else if (sel < 84)
            begin
                fill_random_values();
                push_frame($urandom_range(0, FRAME_BYTES - 1), -1, 0);
            end
            else if (sel < 90)
            begin
                repeat ($urandom_range(1, 3)) push_byte(model_header[15:8]);
                push_byte($urandom_range(0, 1) ? model_header[7:0] : 8'($urandom));
            end
            else
            begin
                burst = model_dead + 3;
                if (burst > 40)
                    burst = 40;
                push_ticks($urandom_range(1, burst));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_DEF_CH0_3:   model_defaults[0] = value;
            REG_DEF_CH4_7:   model_defaults[1] = value;
            REG_DEF_CH8_11:  model_defaults[2] = value;
            REG_DEF_CH12_13: model_defaults[3] = {32'd0, value[31:0]};
            REG_DEAD_TIME:   model_dead = value[15:0];
            REG_HEADER:      model_header = value[15:0];
            default:         ;
        endcase
    endtask

    task automatic configure(input logic [63:0] d0, input logic [63:0] d1,
                             input logic [63:0] d2, input logic [31:0] d3,
                             input logic [15:0] dead, input logic [15:0] hdr);
        write_reg(REG_DEF_CH0_3, d0);
        write_reg(REG_DEF_CH4_7, d1);
        write_reg(REG_DEF_CH8_11, d2);
        write_reg(REG_DEF_CH12_13, {$urandom, d3});
        write_reg(REG_DEAD_TIME, {$urandom, 16'($urandom), dead});
        write_reg(REG_HEADER, {$urandom, 16'($urandom), hdr});
    endtask

    task automatic wait_drain();
        while (rx_events.size() != 0 || expected_channels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        model_defaults[0] = DEF_QUAD_RESET;
        model_defaults[1] = DEF_QUAD_RESET;
        model_defaults[2] = DEF_QUAD_RESET;
        model_defaults[3] = {32'd0, DEF_PAIR_RESET};
        model_dead   = DEAD_RESET;
        model_header = HEADER_RESET;
        model_phase  = HUNTING;
        model_count  = 0;
        model_link   = 1'b0;
        model_idle   = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            model_store[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: false and repeated header bytes, limits, header-like payload
        push_byte(model_header[15:8]);
        push_byte(model_header[7:0] ^ 8'h01);
        push_byte(model_header[7:0]);
        push_byte(model_header[15:8]);
        frame_values = '{LOW_LIMIT, LOW_LIMIT + 16'd1, HIGH_LIMIT - 16'd1, HIGH_LIMIT,
                         16'h0000, VALUE_MAX, 16'h2040, 16'h4020, 16'd1500, 16'h2020,
                         16'h4040, 16'd1000, 16'd2000, 16'd1234};
        push_frame(-1, -1, 0);
        push_ticks(8);
        wait_drain();

        // equal header bytes, dead time of one tick, link dying mid-frame
        configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 16'd1, 16'h5555);
        fill_random_values();
        push_frame(-1, 10, 3);
        push_ticks(2);
        push_random(100);
        hold_request = 1'b1;
        wait_drain();

        configure('0, '1, {$urandom, $urandom}, '1, 16'($urandom_range(2, 20)), 16'h0000);
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        push_random(90);
        wait_drain();

        // long dead time, link stays up
        configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, VALUE_MAX - 16'd1, 16'($urandom));
        push_byte(8'($urandom));
        push_ticks(20);
        wait_drain();

        configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, VALUE_MAX, 16'hFFFF);
        push_random(40);
        push_ticks(20);
        wait_drain();

        configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 16'($urandom_range(1, 30)), 16'($urandom));
        push_random(50);
        while (rx_events.size() != 0)
            @(posedge clk);
        no_gaps = 1'b1;
        push_random(60);
        wait_drain();

        if (errors == 0)
            $display("[rc_channel_frame_receiver] OK");
        else
            $display("[rc_channel_frame_receiver] ERROR");
        $finish;
    end

endmodule
